>>> hw/rtl/mccf_pkg.sv
package mccf_pkg;

  // action codes of an input transaction
  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_PEEK  = 2'd1,
    ACT_POP   = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  // status codes of a result transaction
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  localparam int unsigned FILL_W = 9;

  // one stored command entry
  typedef struct packed {
    logic [15:0] port;
    logic [7:0]  code;
    logic [7:0]  mode;
    logic [7:0]  motor;
    logic [31:0] steps;
    logic [31:0] speed;
    logic [31:0] address;
  } entry_t;

endpackage

>>> hw/rtl/multi_channel_command_fifo_core.sv
// channel | direction | ports
// --------+-----------+----------------------------------------------------------
// in      | input     | in_valid, in_stall (out), action, queue_id, entry fields
// out     | output    | out_valid, out_stall (in), status, fill_count, is_empty, head
//
// one transaction per cycle while in_stall is low; each result appears the cycle after acceptance
// the entry store is one synchronous ram, one access (push write or peek read) per
// transaction, so a push followed at once by a peek of that slot sees the new entry
// head, tail and count live in flip-flops per channel, set by reset (head to one, tail and count to zero); no ram sweep
// in_stall rises only while a result waits and out_stall holds it

module multi_channel_command_fifo_core import mccf_pkg::*; #(
  parameter int unsigned CHANNELS = 4,
  parameter int unsigned DEPTH    = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_queue_id,
  input  logic [15:0] in_dest_port,
  input  logic [7:0]  in_command_code,
  input  logic [7:0]  in_queue_mode,
  input  logic [31:0] in_step_count,
  input  logic [31:0] in_step_speed,
  input  logic [7:0]  in_target_motor,
  input  logic [31:0] in_source_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [8:0]  out_fill_count,
  output logic        out_is_empty,
  output logic [15:0] out_head_port,
  output logic [7:0]  out_head_code,
  output logic [7:0]  out_head_mode,
  output logic [31:0] out_head_steps,
  output logic [31:0] out_head_speed,
  output logic [7:0]  out_head_motor,
  output logic [31:0] out_head_address
);

  localparam int unsigned CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W    = CH_W + PTR_W;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // per-channel pointers and counts
  logic [PTR_W-1:0] head_r  [CHANNELS];
  logic [PTR_W-1:0] tail_r  [CHANNELS];
  logic [CNT_W-1:0] count_r [CHANNELS];

  // entry store
  entry_t mem [MEM_DEPTH];
  entry_t rdata_r;

  // output register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [FILL_W-1:0] out_count_r;
  logic              out_empty_r;
  logic              out_peek_r;

  logic              accept;
  logic              ch_ok;
  logic [CH_W-1:0]   ch;
  action_t           act;
  logic [PTR_W-1:0]  head_cur, tail_cur, head_nxt, tail_nxt, tail_inc, head_inc;
  logic [CNT_W-1:0]  cnt_cur, cnt_nxt;
  status_t           status_nxt;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CNT_W+FILL_W-1:0] cnt_ext;
  entry_t            wdata;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // decode channel and action
  assign ch_ok    = ({1'b0, in_queue_id} < 9'(CHANNELS));
  assign ch       = in_queue_id[CH_W-1:0];
  assign act      = action_t'(in_action);
  assign head_cur = head_r[ch];
  assign tail_cur = tail_r[ch];
  assign cnt_cur  = count_r[ch];
  assign tail_inc = (tail_cur == PTR_LAST) ? '0 : tail_cur + PTR_ONE;
  assign head_inc = (head_cur == PTR_LAST) ? '0 : head_cur + PTR_ONE;

  // next pointer state and status of the transaction
  always_comb begin
    head_nxt   = head_cur;
    tail_nxt   = tail_cur;
    cnt_nxt    = cnt_cur;
    status_nxt = ST_OK;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    if (!ch_ok) begin
      status_nxt = ST_BAD;
    end else begin
      case (act)
        ACT_PUSH: begin
          if (cnt_cur >= CNT_FULL) begin
            status_nxt = ST_FULL;
          end else begin
            tail_nxt = tail_inc;
            cnt_nxt  = cnt_cur + CNT_W'(1);
            wr_en    = 1'b1;
          end
        end
        ACT_PEEK: begin
          if (cnt_cur == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            rd_en = 1'b1;
          end
        end
        ACT_POP: begin
          if (cnt_cur == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            head_nxt = head_inc;
            cnt_nxt  = cnt_cur - CNT_W'(1);
          end
        end
        ACT_CLEAR: begin
          head_nxt = tail_inc;
          cnt_nxt  = '0;
        end
        default: begin
          status_nxt = ST_BAD;
        end
      endcase
    end
  end

  assign wr_addr = {ch, tail_inc};
  assign rd_addr = {ch, head_cur};
  assign cnt_ext = {{FILL_W{1'b0}}, cnt_nxt};

  assign wdata.port    = in_dest_port;
  assign wdata.code    = in_command_code;
  assign wdata.mode    = in_queue_mode;
  assign wdata.motor   = in_target_motor;
  assign wdata.steps   = in_step_count;
  assign wdata.speed   = in_step_speed;
  assign wdata.address = in_source_address;

  // entry ram, one access per transaction
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (accept && rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // pointer and count update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        head_r[i]  <= PTR_ONE;
        tail_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else if (accept && ch_ok) begin
      head_r[ch]  <= head_nxt;
      tail_r[ch]  <= tail_nxt;
      count_r[ch] <= cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_count_r  <= ch_ok ? cnt_ext[FILL_W-1:0] : '0;
      out_empty_r  <= ch_ok && (cnt_nxt == '0);
      out_peek_r   <= rd_en;
    end
  end

  // head fields only on a successful peek
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_fill_count   = out_count_r;
  assign out_is_empty     = out_empty_r;
  assign out_head_port    = out_peek_r ? rdata_r.port    : '0;
  assign out_head_code    = out_peek_r ? rdata_r.code    : '0;
  assign out_head_mode    = out_peek_r ? rdata_r.mode    : '0;
  assign out_head_steps   = out_peek_r ? rdata_r.steps   : '0;
  assign out_head_speed   = out_peek_r ? rdata_r.speed   : '0;
  assign out_head_motor   = out_peek_r ? rdata_r.motor   : '0;
  assign out_head_address = out_peek_r ? rdata_r.address : '0;

  // checks
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction gave no result");

  a_bad_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_BAD) |-> (out_count_r == '0 && !out_empty_r && !out_peek_r))
    else $error("bad channel result carries data");

  a_peek_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_peek_r) |-> (out_status_r == ST_OK && !out_empty_r))
    else $error("head fields shown on a refused transaction");

  a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_peek_r && out_stall) |=> $stable(rdata_r))
    else $error("read data changed under a stalled result");

endmodule

>>> bench/multi_channel_command_fifo_core_test.sv
`timescale 1ns / 1ps

module multi_channel_command_fifo_core_test;
  import mccf_pkg::*;

  localparam int CHANNELS = 4;
  localparam int DEPTH    = 256;

  // one result transaction as seen on the output channel
  typedef struct packed {
    status_t             status;
    logic [FILL_W-1:0]   fill;
    logic                empty;
    entry_t              head;
  } fifo_result_t;

  // mirror of the channel queues plus the results still awaited
  class command_fifo_scoreboard;
    entry_t       slot_mirror [CHANNELS][DEPTH];
    int           head_ptr [CHANNELS];
    int           tail_ptr [CHANNELS];
    int           entry_total [CHANNELS];
    fifo_result_t awaited_results [$];
    int unsigned  errors;

    function new();
      for (int c = 0; c < CHANNELS; c++) begin
        head_ptr[c]    = 1 % DEPTH;
        tail_ptr[c]    = 0;
        entry_total[c] = 0;
      end
      errors = 0;
    endfunction

    // apply one accepted command and queue the result it should produce
    function void note_command(action_t act, logic [7:0] qid, entry_t e);
      fifo_result_t r;
      int c;
      r = '0;
      r.status = ST_OK;
      if (qid >= CHANNELS) begin
        r.status = ST_BAD;
      end else begin
        c = int'(qid);
        case (act)
          ACT_PUSH: begin
            if (entry_total[c] >= DEPTH) begin
              r.status = ST_FULL;
            end else begin
              tail_ptr[c] = (tail_ptr[c] + 1) % DEPTH;
              slot_mirror[c][tail_ptr[c]] = e;
              entry_total[c]++;
            end
          end
          ACT_PEEK: begin
            if (entry_total[c] == 0) r.status = ST_EMPTY;
            else r.head = slot_mirror[c][head_ptr[c]];
          end
          ACT_POP: begin
            if (entry_total[c] == 0) begin
              r.status = ST_EMPTY;
            end else begin
              head_ptr[c] = (head_ptr[c] + 1) % DEPTH;
              entry_total[c]--;
            end
          end
          default: begin
            head_ptr[c]    = (tail_ptr[c] + 1) % DEPTH;
            entry_total[c] = 0;
          end
        endcase
        r.fill  = FILL_W'(entry_total[c]);
        r.empty = (entry_total[c] == 0);
      end
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
        errors++;
      end
    endfunction

    // match one result transaction against the oldest awaited one
    function void check_result(fifo_result_t seen);
      fifo_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d fill %0d", $time, seen.status,
                 seen.fill);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("status", 32'(want.status), 32'(seen.status));
      compare_field("fill_count", 32'(want.fill), 32'(seen.fill));
      compare_field("is_empty", 32'(want.empty), 32'(seen.empty));
      compare_field("head_port", 32'(want.head.port), 32'(seen.head.port));
      compare_field("head_code", 32'(want.head.code), 32'(seen.head.code));
      compare_field("head_mode", 32'(want.head.mode), 32'(seen.head.mode));
      compare_field("head_steps", want.head.steps, seen.head.steps);
      compare_field("head_speed", want.head.speed, seen.head.speed);
      compare_field("head_motor", 32'(want.head.motor), 32'(seen.head.motor));
      compare_field("head_address", want.head.address, seen.head.address);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [7:0]  in_queue_id;
  logic [15:0] in_dest_port;
  logic [7:0]  in_command_code;
  logic [7:0]  in_queue_mode;
  logic [31:0] in_step_count;
  logic [31:0] in_step_speed;
  logic [7:0]  in_target_motor;
  logic [31:0] in_source_address;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [8:0]  out_fill_count;
  logic        out_is_empty;
  logic [15:0] out_head_port;
  logic [7:0]  out_head_code;
  logic [7:0]  out_head_mode;
  logic [31:0] out_head_steps;
  logic [31:0] out_head_speed;
  logic [7:0]  out_head_motor;
  logic [31:0] out_head_address;

  command_fifo_scoreboard board;
  fifo_result_t           returned;
  bit                     calm;
  bit                     want_hold;
  int unsigned            offered;

  multi_channel_command_fifo_core #(
    .CHANNELS(CHANNELS),
    .DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_queue_id(in_queue_id),
    .in_dest_port(in_dest_port),
    .in_command_code(in_command_code),
    .in_queue_mode(in_queue_mode),
    .in_step_count(in_step_count),
    .in_step_speed(in_step_speed),
    .in_target_motor(in_target_motor),
    .in_source_address(in_source_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_fill_count(out_fill_count),
    .out_is_empty(out_is_empty),
    .out_head_port(out_head_port),
    .out_head_code(out_head_code),
    .out_head_mode(out_head_mode),
    .out_head_steps(out_head_steps),
    .out_head_speed(out_head_speed),
    .out_head_motor(out_head_motor),
    .out_head_address(out_head_address)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign returned = '{
    status: status_t'(out_status),
    fill:   out_fill_count,
    empty:  out_is_empty,
    head:   '{port: out_head_port, code: out_head_code, mode: out_head_mode,
              motor: out_head_motor, steps: out_head_steps, speed: out_head_speed,
              address: out_head_address}
  };

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(returned);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (want_hold) begin
        want_hold = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 38);
      end
    end
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic entry_t random_entry();
    entry_t e;
    case ($urandom_range(0, 9))
      0: e = '0;
      1: e = '1;
      default: begin
        e.port    = 16'($urandom);
        e.code    = 8'($urandom);
        e.mode    = 8'($urandom);
        e.motor   = 8'($urandom);
        e.steps   = $urandom;
        e.speed   = $urandom;
        e.address = $urandom;
      end
    endcase
    return e;
  endfunction

  // offer one command transaction and wait until it is taken
  task automatic offer_command(action_t act, logic [7:0] qid, entry_t e);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= act;
    in_queue_id       <= qid;
    in_dest_port      <= e.port;
    in_command_code   <= e.code;
    in_queue_mode     <= e.mode;
    in_step_count     <= e.steps;
    in_step_speed     <= e.speed;
    in_target_motor   <= e.motor;
    in_source_address <= e.address;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_command(act, qid, e);
    offered++;
  endtask

  // mix of well-formed command sequences and some noise
  task automatic random_mix(int unsigned quota);
    int unsigned start;
    int          len;
    logic [7:0]  ch;
    action_t     act;
    start = offered;
    while (offered - start < quota) begin
      ch  = 8'($urandom_range(0, CHANNELS - 1));
      len = $urandom_range(1, 6);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat (len) offer_command(ACT_PUSH, ch, random_entry());
        4, 5: begin
          repeat (len) begin
            act = ($urandom_range(0, 2) == 0) ? ACT_PEEK : ACT_POP;
            offer_command(act, ch, random_entry());
          end
        end
        6: offer_command(ACT_CLEAR, ch, random_entry());
        7: offer_command(action_t'($urandom_range(0, 3)), ch, random_entry());
        8: begin
          offer_command(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        random_entry());
        end
        default: begin
          offer_command(ACT_PUSH, ch, random_entry());
          offer_command(ACT_PEEK, ch, random_entry());
        end
      endcase
    end
  endtask

  initial begin
    int         guard;
    int         need;
    logic [7:0] ch;
    board             = new();
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_action         = ACT_PUSH;
    in_queue_id       = '0;
    in_dest_port      = '0;
    in_command_code   = '0;
    in_queue_mode     = '0;
    in_step_count     = '0;
    in_step_speed     = '0;
    in_target_motor   = '0;
    in_source_address = '0;
    out_stall         = 1'b0;
    calm              = 1'b1;
    want_hold         = 1'b0;
    offered           = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty refusals, extremes, back-to-back push and peek, clear, bad channels
    offer_command(ACT_PEEK, 0, random_entry());
    offer_command(ACT_POP, 0, random_entry());
    offer_command(ACT_CLEAR, 2, random_entry());
    offer_command(ACT_PUSH, 0, '0);
    offer_command(ACT_PUSH, 0, '1);
    offer_command(ACT_PEEK, 0, random_entry());
    offer_command(ACT_POP, 0, random_entry());
    offer_command(ACT_PEEK, 0, random_entry());
    offer_command(ACT_PUSH, 1, random_entry());
    offer_command(ACT_PEEK, 1, random_entry());
    offer_command(ACT_PUSH, 3, random_entry());
    offer_command(ACT_PUSH, 3, random_entry());
    offer_command(ACT_CLEAR, 3, random_entry());
    offer_command(ACT_PEEK, 3, random_entry());
    offer_command(ACT_POP, 3, random_entry());
    offer_command(ACT_PUSH, 3, random_entry());
    offer_command(ACT_PEEK, 3, random_entry());
    offer_command(ACT_PUSH, 4, random_entry());
    offer_command(ACT_PEEK, 255, random_entry());
    offer_command(ACT_POP, 128, random_entry());
    offer_command(ACT_CLEAR, 4, random_entry());
    offer_command(ACT_PUSH, 255, '1);
    offer_command(ACT_CLEAR, 0, random_entry());
    calm = 1'b0;

    random_mix(60);

    // fill one channel past full, work it down with pops and peeks, then refill and clear it
    ch   = 8'($urandom_range(0, CHANNELS - 1));
    need = DEPTH - board.entry_total[ch];
    repeat (need + 3) offer_command(ACT_PUSH, ch, random_entry());
    offer_command(ACT_PEEK, ch, random_entry());
    repeat (40) begin
      offer_command(($urandom_range(0, 3) == 0) ? ACT_PEEK : ACT_POP, ch, random_entry());
    end
    repeat (30) offer_command(ACT_PUSH, ch, random_entry());
    offer_command(ACT_CLEAR, ch, random_entry());
    offer_command(ACT_PEEK, ch, random_entry());

    // stretch with no idling on either side
    calm = 1'b1;
    random_mix(40);
    calm = 1'b0;

    // long receiver hold-off while commands keep coming
    want_hold = 1'b1;
    random_mix(60);
    in_valid <= 1'b0;

    for (guard = 0; guard < 50000 && board.awaited_results.size() != 0; guard++)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.awaited_results.size() != 0)
      $display("%0t: %0d results never arrived", $time, board.awaited_results.size());
    if (board.errors == 0 && board.awaited_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/mccf_pkg.sv
hw/rtl/multi_channel_command_fifo_core.sv
bench/multi_channel_command_fifo_core_test.sv
